### design/rca_pkg.sv
// Shared types and constants for the ring chunk allocator.
// Holds the request and response structs and the request and status codes.
// No dependencies.
package rca_pkg;

    localparam int OFFSET_W = 20;
    localparam int COUNT_W  = 21;
    localparam int SIZE_W   = OFFSET_W + 1;

    localparam logic [SIZE_W-1:0] RING_SIZE_MAX   = SIZE_W'(1) << OFFSET_W;
    localparam logic [SIZE_W-1:0] RING_SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] RING_SIZE_RESET = RING_SIZE_MAX;

    localparam logic [1:0] REQ_PROBE = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [1:0] ST_FREE_OVER = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COUNT_W-1:0] req_count;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] chunk_offset;
    } t_rsp;

endpackage

### design/rca_core.sv
// Offset state of the ring allocator and the single-pass decision logic.
// Depends on rca_pkg for the request and response types and codes.
module rca_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rca_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  logic                        i_fire,
    input  rca_pkg::t_req               i_req,
    output rca_pkg::t_rsp               o_rsp
);
    import rca_pkg::*;

    localparam int SUM_W = OFFSET_W + 2;

    logic [SIZE_W-1:0]   r_size;
    logic [OFFSET_W-1:0] r_oldest;
    logic [OFFSET_W-1:0] r_next;
    logic [SIZE_W-1:0]   r_wrap_end;

    logic [SIZE_W-1:0]   n_size;
    logic [OFFSET_W-1:0] n_oldest;
    logic [OFFSET_W-1:0] n_next;
    logic [SIZE_W-1:0]   n_wrap_end;

    logic [SIZE_W-1:0]   cfg_size;
    logic                cnt_zero;
    logic [SUM_W-1:0]    cnt_ext;
    logic [SUM_W-1:0]    alloc_sum;
    logic                alloc_ok;
    logic                alloc_wraps;
    logic [OFFSET_W-1:0] alloc_start;
    logic [OFFSET_W-1:0] alloc_next;

    logic                free_step;
    logic [OFFSET_W-1:0] free_first;
    logic [COUNT_W-1:0]  free_cnt;
    logic [SIZE_W-1:0]   free_end;
    logic [SUM_W-1:0]    free_sum;
    logic                free_ok;

    // Out-of-range sizes are clamped once, when the register is written.
    always_comb begin
        if (i_cfg_wdata < RING_SIZE_MIN) begin
            cfg_size = RING_SIZE_MIN;
        end else if (i_cfg_wdata > RING_SIZE_MAX) begin
            cfg_size = RING_SIZE_MAX;
        end else begin
            cfg_size = i_cfg_wdata;
        end
    end

    assign cnt_zero  = (i_req.req_count == '0);
    assign cnt_ext   = SUM_W'(i_req.req_count);
    assign alloc_sum = SUM_W'(r_next) + cnt_ext;

    always_comb begin
        alloc_ok    = 1'b0;
        alloc_wraps = 1'b0;
        alloc_start = r_next;
        alloc_next  = r_next;
        if (cnt_zero) begin
            alloc_ok = 1'b1;
        end else if (r_next > r_oldest) begin
            if (alloc_sum < SUM_W'(r_size)) begin
                alloc_ok   = 1'b1;
                alloc_next = alloc_sum[OFFSET_W-1:0];
            end else if (alloc_sum == SUM_W'(r_size)) begin
                alloc_ok   = (r_oldest != '0);
                alloc_next = '0;
            end else begin
                // Tail too short: restart the chunk at offset zero.
                alloc_ok    = (cnt_ext < SUM_W'(r_oldest));
                alloc_wraps = 1'b1;
                alloc_start = '0;
                alloc_next  = i_req.req_count[OFFSET_W-1:0];
            end
        end else begin
            alloc_ok   = (alloc_sum < SUM_W'(r_oldest));
            alloc_next = alloc_sum[OFFSET_W-1:0];
        end
    end

    // Reaching the wrap end costs one byte to step back to offset zero.
    assign free_step  = (r_wrap_end != '0) && (SIZE_W'(r_oldest) == r_wrap_end - SIZE_W'(1));
    assign free_first = free_step ? '0 : r_oldest;
    assign free_cnt   = free_step ? i_req.req_count - COUNT_W'(1) : i_req.req_count;
    assign free_end   = free_step ? r_size : r_wrap_end;
    assign free_sum   = SUM_W'(free_first) + SUM_W'(free_cnt);

    always_comb begin
        if (free_first <= r_next) begin
            free_ok = cnt_zero || (free_sum < SUM_W'(r_next));
        end else begin
            free_ok = cnt_zero || (free_sum < SUM_W'(free_end));
        end
    end

    always_comb begin
        n_size       = r_size;
        n_oldest     = r_oldest;
        n_next       = r_next;
        n_wrap_end   = r_wrap_end;
        o_rsp.status       = ST_OK;
        o_rsp.chunk_offset = r_next;
        case (i_req.req_type)
            REQ_ALLOC: begin
                if (alloc_ok) begin
                    n_next             = alloc_next;
                    o_rsp.chunk_offset = alloc_start;
                    if (alloc_wraps) begin
                        n_wrap_end = SIZE_W'(r_next);
                    end
                end else begin
                    o_rsp.status = ST_NO_ROOM;
                end
            end
            REQ_FREE: begin
                if (!free_ok) begin
                    o_rsp.status = ST_FREE_OVER;
                end else if (!cnt_zero) begin
                    n_oldest   = free_sum[OFFSET_W-1:0];
                    n_wrap_end = free_end;
                end
            end
            default: begin
                if (!alloc_ok) begin
                    o_rsp.status = ST_NO_ROOM;
                end
            end
        endcase
        if (!i_fire) begin
            n_oldest   = r_oldest;
            n_next     = r_next;
            n_wrap_end = r_wrap_end;
        end
        if (i_cfg_we) begin
            n_size     = cfg_size;
            n_oldest   = '0;
            n_next     = OFFSET_W'(1);
            n_wrap_end = cfg_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= RING_SIZE_RESET;
            r_oldest   <= '0;
            r_next     <= OFFSET_W'(1);
            r_wrap_end <= RING_SIZE_RESET;
        end else begin
            r_size     <= n_size;
            r_oldest   <= n_oldest;
            r_next     <= n_next;
            r_wrap_end <= n_wrap_end;
        end
    end

endmodule

### design/ring_chunk_allocator_top.sv
// Top level of the ring chunk allocator: request register, result register
// and the rca_core offset logic between them. Depends on rca_pkg and rca_core.

// Takes one request per clock while the output is not stalled and gives one
// result per request, in order. An accepted request is held in the request
// register and is evaluated against the three offsets once the result register
// is free or drains; its result is then registered in the result register
// and shown on the output. Sustained throughput is one request per cycle while
// the output is not stalled, set by the single update of the offset registers
// per cycle. Writing ring_size re-initialises the offsets for the new size;
// sizes below 2 or above 2^20 are clamped.
module ring_chunk_allocator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rca_pkg::t_req               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rca_pkg::t_rsp               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [rca_pkg::SIZE_W-1:0]  i_cfg_wdata
);
    import rca_pkg::*;

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    t_rsp core_rsp;
    logic advance;

    // The held request moves on whenever the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    rca_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (advance),
        .i_req       (r_in),
        .o_rsp       (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### design/rca_checker.sv
// Port-level checker for the ring chunk allocator, bound to the top level.
// Depends on rca_pkg for the response type and status codes.
module rca_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  rca_pkg::t_rsp               o_out_data
);
    import rca_pkg::*;

    // A stalled result must hold still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_NO_ROOM
                         || o_out_data.status == ST_FREE_OVER))
        else $error("illegal status code");

    // An accepted request always leaves a result pending once it has passed the request register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("accepted request produced no result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ring_chunk_allocator_top rca_checker u_rca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
